### hw/rtl/ctt_pkg.sv
// Shared types, codes and character-class functions of the text tokeniser.
`default_nettype none

package ctt_pkg;

    localparam int LINE_BITS_DEFAULT = 16;

    // Token kinds.
    localparam logic [4:0] KIND_NEWLINE = 5'd0;
    localparam logic [4:0] KIND_END     = 5'd1;
    localparam logic [4:0] KIND_IDENT   = 5'd2;
    localparam logic [4:0] KIND_BOOL    = 5'd3;
    localparam logic [4:0] KIND_NUMBER  = 5'd4;
    localparam logic [4:0] KIND_STRING  = 5'd5;
    localparam logic [4:0] KIND_SYM0    = 5'd6;
    localparam logic [4:0] KIND_NONE    = 5'd29;

    // Error codes.
    localparam logic [1:0] ERR_NONE     = 2'd0;
    localparam logic [1:0] ERR_CHAR     = 2'd1;
    localparam logic [1:0] ERR_UNTERM   = 2'd2;

    // Keyword matcher progress codes.
    localparam logic [3:0] KW_START     = 4'd0;
    localparam logic [3:0] KW_T         = 4'd1;
    localparam logic [3:0] KW_TR        = 4'd2;
    localparam logic [3:0] KW_TRU       = 4'd3;
    localparam logic [3:0] KW_TRUE      = 4'd4;
    localparam logic [3:0] KW_F         = 4'd5;
    localparam logic [3:0] KW_FA        = 4'd6;
    localparam logic [3:0] KW_FAL       = 4'd7;
    localparam logic [3:0] KW_FALS      = 4'd8;
    localparam logic [3:0] KW_FALSE     = 4'd9;
    localparam logic [3:0] KW_DEAD      = 4'd15;

    localparam logic [7:0] CH_UNDERSCORE = 8'h5F;
    localparam logic [7:0] CH_NEWLINE    = 8'h0A;
    localparam logic [7:0] CH_PERIOD     = 8'h2E;
    localparam logic [7:0] CH_QUOTE      = 8'h22;

    typedef enum logic [5:0] {
        MODE_IDLE     = 6'b000001,
        MODE_IDENT    = 6'b000010,
        MODE_NUM      = 6'b000100,
        MODE_STR      = 6'b001000,
        MODE_ERR_CHAR = 6'b010000,
        MODE_ERR_STR  = 6'b100000
    } mode_t;

    typedef struct packed {
        logic [4:0]  token_kind;
        logic        char_valid;
        logic [7:0]  char_out;
        logic        token_start;
        logic        token_end;
        logic [15:0] line_number;
        logic [1:0]  error_code;
        logic        last_result;
    } result_t;

    function automatic logic is_alpha(input logic [7:0] c);
        is_alpha = (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A);
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        is_digit = (c >= 8'h30 && c <= 8'h39);
    endfunction

    function automatic logic is_space(input logic [7:0] c);
        is_space = (c == 8'h20) || (c >= 8'h09 && c <= 8'h0D);
    endfunction

    // Symbol kind of a punctuation byte, or KIND_NONE when it is not one.
    function automatic logic [4:0] sym_kind(input logic [7:0] c);
        case (c)
            8'h2E:   sym_kind = 5'd6;
            8'h2C:   sym_kind = 5'd7;
            8'h3A:   sym_kind = 5'd8;
            8'h3B:   sym_kind = 5'd9;
            8'h40:   sym_kind = 5'd10;
            8'h23:   sym_kind = 5'd11;
            8'h24:   sym_kind = 5'd12;
            8'h25:   sym_kind = 5'd13;
            8'h5E:   sym_kind = 5'd14;
            8'h26:   sym_kind = 5'd15;
            8'h2A:   sym_kind = 5'd16;
            8'h2B:   sym_kind = 5'd17;
            8'h2D:   sym_kind = 5'd18;
            8'h2F:   sym_kind = 5'd19;
            8'h5C:   sym_kind = 5'd20;
            8'h28:   sym_kind = 5'd21;
            8'h29:   sym_kind = 5'd22;
            8'h5B:   sym_kind = 5'd23;
            8'h5D:   sym_kind = 5'd24;
            8'h7B:   sym_kind = 5'd25;
            8'h7D:   sym_kind = 5'd26;
            8'h3C:   sym_kind = 5'd27;
            8'h3E:   sym_kind = 5'd28;
            default: sym_kind = KIND_NONE;
        endcase
    endfunction

    // Step of the matcher that recognises the words true and false.
    function automatic logic [3:0] kw_next(input logic [3:0] p, input logic [7:0] c);
        case (p)
            KW_START: kw_next = (c == 8'h74) ? KW_T : ((c == 8'h66) ? KW_F : KW_DEAD);
            KW_T:     kw_next = (c == 8'h72) ? KW_TR : KW_DEAD;
            KW_TR:    kw_next = (c == 8'h75) ? KW_TRU : KW_DEAD;
            KW_TRU:   kw_next = (c == 8'h65) ? KW_TRUE : KW_DEAD;
            KW_F:     kw_next = (c == 8'h61) ? KW_FA : KW_DEAD;
            KW_FA:    kw_next = (c == 8'h6C) ? KW_FAL : KW_DEAD;
            KW_FAL:   kw_next = (c == 8'h73) ? KW_FALS : KW_DEAD;
            KW_FALS:  kw_next = (c == 8'h65) ? KW_FALSE : KW_DEAD;
            default:  kw_next = KW_DEAD;
        endcase
    endfunction

    function automatic result_t make_res(
        input logic [4:0]  kind,
        input logic        cv,
        input logic [7:0]  ch,
        input logic        st,
        input logic        en,
        input logic [1:0]  err,
        input logic [15:0] line
    );
        result_t r;
        r.token_kind  = kind;
        r.char_valid  = cv;
        r.char_out    = cv ? ch : 8'h00;
        r.token_start = st;
        r.token_end   = en;
        r.line_number = line;
        r.error_code  = err;
        r.last_result = 1'b0;
        make_res = r;
    endfunction

endpackage

`default_nettype wire

### hw/rtl/ctt_in_if.sv
// Input channel of the tokeniser: one text byte or an end mark per item.
`default_nettype none

interface ctt_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] byte_in;
    logic       end_of_input;

    modport source (output valid, output byte_in, output end_of_input, input ready);
    modport sink (input valid, input byte_in, input end_of_input, output ready);
endinterface

`default_nettype wire

### hw/rtl/ctt_out_if.sv
// Output channel of the tokeniser: one token result per item.
`default_nettype none

interface ctt_out_if;
    logic        valid;
    logic        ready;
    logic [4:0]  token_kind;
    logic        char_valid;
    logic [7:0]  char_out;
    logic        token_start;
    logic        token_end;
    logic [15:0] line_number;
    logic [1:0]  error_code;
    logic        last_result;

    modport source (
        output valid, output token_kind, output char_valid, output char_out,
        output token_start, output token_end, output line_number,
        output error_code, output last_result, input ready
    );
    modport sink (
        input valid, input token_kind, input char_valid, input char_out,
        input token_start, input token_end, input line_number,
        input error_code, input last_result, output ready
    );
endinterface

`default_nettype wire

### hw/rtl/config_text_tokenizer.sv
// Text tokeniser for configuration files: bytes in, framed token items out.
//
// tok_in takes one item per byte of text, or an end mark that closes the
// text. tok_out gives the token items: identifier, number and string
// characters one item each, framed by start and end marks, plus newline,
// end, symbol and error items. One input item causes zero, one or two
// output items; the last one carries last_result.
// An accepted item shows its first result in the next cycle. While the
// receiver is ready, the input takes one item per cycle as long as each
// causes at most one result; an item that causes two (a token closed by
// the byte that starts the next) holds off the next item while the
// two-entry result buffer drains one item per cycle. tok_in.ready is high
// when the buffer will be empty after this cycle's output transfer.
// When the receiver stalls, results wait in the buffer and the input is
// held off once it cannot take a further item.
// Reset empties the buffer, returns to the idle mode and sets the line
// count to one. Unknown bytes and unterminated strings leave a sticky error
// that only reset clears.
`default_nettype none

module config_text_tokenizer #(
    parameter int LINE_BITS = ctt_pkg::LINE_BITS_DEFAULT
) (
    input  wire        clk,
    input  wire        rst_n,
    ctt_in_if.sink     tok_in,
    ctt_out_if.source  tok_out
);

    ctt_pkg::mode_t         mode_reg, mode_next;
    logic                   period_reg, period_next;
    logic [3:0]             kw_reg, kw_next_v;
    logic [LINE_BITS-1:0]   line_reg, line_next;

    ctt_pkg::result_t       slot0_reg, slot0_next;
    ctt_pkg::result_t       slot1_reg, slot1_next;
    logic [1:0]             count_reg, count_next;

    logic [7:0]             c;
    logic                   eoi;
    logic [15:0]            line16;
    logic                   accept;
    logic                   pop;
    logic                   run_fresh;
    logic                   has_first;
    logic                   has_fresh;
    ctt_pkg::result_t       first_res;
    ctt_pkg::result_t       fresh_res;
    ctt_pkg::result_t       r0;
    ctt_pkg::result_t       r1;
    logic [4:0]             sym;

    assign c      = tok_in.byte_in;
    assign eoi    = tok_in.end_of_input;
    assign line16 = 16'(line_reg);
    assign sym    = ctt_pkg::sym_kind(c);

    assign pop          = tok_out.valid && tok_out.ready;
    assign tok_in.ready = (count_reg == 2'd0) || (count_reg == 2'd1 && tok_out.ready);
    assign accept       = tok_in.valid && tok_in.ready;

    // Work out the results of the offered item and the state it leaves.
    always_comb
    begin
        mode_next   = mode_reg;
        period_next = period_reg;
        kw_next_v   = kw_reg;
        line_next   = line_reg;
        run_fresh   = 1'b0;
        has_first   = 1'b0;
        has_fresh   = 1'b0;
        first_res   = ctt_pkg::make_res(ctt_pkg::KIND_NONE, 1'b0, 8'h00, 1'b0, 1'b0,
                                        ctt_pkg::ERR_NONE, line16);
        fresh_res   = first_res;

        case (mode_reg)
            ctt_pkg::MODE_ERR_CHAR:
            begin
                has_first = 1'b1;
                first_res = ctt_pkg::make_res(ctt_pkg::KIND_NONE, 1'b0, 8'h00, 1'b0, 1'b0,
                                              ctt_pkg::ERR_CHAR, line16);
            end
            ctt_pkg::MODE_ERR_STR:
            begin
                has_first = 1'b1;
                first_res = ctt_pkg::make_res(ctt_pkg::KIND_NONE, 1'b0, 8'h00, 1'b0, 1'b0,
                                              ctt_pkg::ERR_UNTERM, line16);
            end
            ctt_pkg::MODE_IDENT:
            begin
                has_first = 1'b1;
                if (!eoi && (ctt_pkg::is_alpha(c) || ctt_pkg::is_digit(c)
                             || c == ctt_pkg::CH_UNDERSCORE))
                begin
                    kw_next_v = ctt_pkg::kw_next(kw_reg, c);
                    first_res = ctt_pkg::make_res(ctt_pkg::KIND_IDENT, 1'b1, c, 1'b0, 1'b0,
                                                  ctt_pkg::ERR_NONE, line16);
                end
                else
                begin
                    first_res = ctt_pkg::make_res(
                        (kw_reg == ctt_pkg::KW_TRUE || kw_reg == ctt_pkg::KW_FALSE)
                            ? ctt_pkg::KIND_BOOL : ctt_pkg::KIND_IDENT,
                        1'b0, 8'h00, 1'b0, 1'b1, ctt_pkg::ERR_NONE, line16);
                    mode_next = ctt_pkg::MODE_IDLE;
                    run_fresh = 1'b1;
                end
            end
            ctt_pkg::MODE_NUM:
            begin
                has_first = 1'b1;
                if (!eoi && (ctt_pkg::is_digit(c) || (c == ctt_pkg::CH_PERIOD && !period_reg)))
                begin
                    if (c == ctt_pkg::CH_PERIOD)
                    begin
                        period_next = 1'b1;
                    end
                    first_res = ctt_pkg::make_res(ctt_pkg::KIND_NUMBER, 1'b1, c, 1'b0, 1'b0,
                                                  ctt_pkg::ERR_NONE, line16);
                end
                else
                begin
                    first_res = ctt_pkg::make_res(ctt_pkg::KIND_NUMBER, 1'b0, 8'h00, 1'b0,
                                                  1'b1, ctt_pkg::ERR_NONE, line16);
                    mode_next = ctt_pkg::MODE_IDLE;
                    run_fresh = 1'b1;
                end
            end
            ctt_pkg::MODE_STR:
            begin
                has_first = 1'b1;
                if (eoi)
                begin
                    first_res = ctt_pkg::make_res(ctt_pkg::KIND_END, 1'b0, 8'h00, 1'b1, 1'b1,
                                                  ctt_pkg::ERR_UNTERM, line16);
                    mode_next = ctt_pkg::MODE_ERR_STR;
                end
                else if (c == ctt_pkg::CH_QUOTE)
                begin
                    first_res = ctt_pkg::make_res(ctt_pkg::KIND_STRING, 1'b0, 8'h00, 1'b0,
                                                  1'b1, ctt_pkg::ERR_NONE, line16);
                    mode_next = ctt_pkg::MODE_IDLE;
                end
                else
                begin
                    first_res = ctt_pkg::make_res(ctt_pkg::KIND_STRING, 1'b1, c, 1'b0, 1'b0,
                                                  ctt_pkg::ERR_NONE, line16);
                end
            end
            default:
            begin
                mode_next = ctt_pkg::MODE_IDLE;
                run_fresh = 1'b1;
            end
        endcase

        // A byte in the idle mode, or the byte that just closed a token.
        if (run_fresh)
        begin
            has_fresh = 1'b1;
            if (eoi)
            begin
                fresh_res = ctt_pkg::make_res(ctt_pkg::KIND_END, 1'b0, 8'h00, 1'b1, 1'b1,
                                              ctt_pkg::ERR_NONE, line16);
                line_next = LINE_BITS'(1);
            end
            else if (c == ctt_pkg::CH_NEWLINE)
            begin
                fresh_res = ctt_pkg::make_res(ctt_pkg::KIND_NEWLINE, 1'b0, 8'h00, 1'b1,
                                              1'b1, ctt_pkg::ERR_NONE, line16);
                if (line_reg != {LINE_BITS{1'b1}})
                begin
                    line_next = line_reg + LINE_BITS'(1);
                end
            end
            else if (ctt_pkg::is_space(c))
            begin
                has_fresh = 1'b0;
            end
            else if (ctt_pkg::is_alpha(c) || c == ctt_pkg::CH_UNDERSCORE)
            begin
                mode_next = ctt_pkg::MODE_IDENT;
                kw_next_v = ctt_pkg::kw_next(ctt_pkg::KW_START, c);
                fresh_res = ctt_pkg::make_res(ctt_pkg::KIND_IDENT, 1'b1, c, 1'b1, 1'b0,
                                              ctt_pkg::ERR_NONE, line16);
            end
            else if (c == ctt_pkg::CH_QUOTE)
            begin
                mode_next = ctt_pkg::MODE_STR;
                fresh_res = ctt_pkg::make_res(ctt_pkg::KIND_STRING, 1'b0, 8'h00, 1'b1, 1'b0,
                                              ctt_pkg::ERR_NONE, line16);
            end
            else if (ctt_pkg::is_digit(c))
            begin
                mode_next   = ctt_pkg::MODE_NUM;
                period_next = 1'b0;
                fresh_res   = ctt_pkg::make_res(ctt_pkg::KIND_NUMBER, 1'b1, c, 1'b1, 1'b0,
                                                ctt_pkg::ERR_NONE, line16);
            end
            else if (sym != ctt_pkg::KIND_NONE)
            begin
                fresh_res = ctt_pkg::make_res(sym, 1'b0, 8'h00, 1'b1, 1'b1,
                                              ctt_pkg::ERR_NONE, line16);
            end
            else
            begin
                mode_next = ctt_pkg::MODE_ERR_CHAR;
                fresh_res = ctt_pkg::make_res(ctt_pkg::KIND_NONE, 1'b0, 8'h00, 1'b0, 1'b0,
                                              ctt_pkg::ERR_CHAR, line16);
            end
        end

        r0             = has_first ? first_res : fresh_res;
        r0.last_result = !(has_first && has_fresh);
        r1             = fresh_res;
        r1.last_result = 1'b1;
    end

    // Result buffer: an accepted item refills it only when it drains empty.
    always_comb
    begin
        slot0_next = slot0_reg;
        slot1_next = slot1_reg;
        count_next = count_reg;
        if (accept)
        begin
            slot0_next = r0;
            slot1_next = r1;
            count_next = 2'(has_first) + 2'(has_fresh);
        end
        else if (pop)
        begin
            slot0_next = slot1_reg;
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= ctt_pkg::MODE_IDLE;
            period_reg <= 1'b0;
            kw_reg     <= ctt_pkg::KW_START;
            line_reg   <= LINE_BITS'(1);
            count_reg  <= 2'd0;
        end
        else
        begin
            count_reg <= count_next;
            if (accept)
            begin
                mode_reg   <= mode_next;
                period_reg <= period_next;
                kw_reg     <= kw_next_v;
                line_reg   <= line_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        slot0_reg <= slot0_next;
        slot1_reg <= slot1_next;
    end

    assign tok_out.valid       = (count_reg != 2'd0);
    assign tok_out.token_kind  = slot0_reg.token_kind;
    assign tok_out.char_valid  = slot0_reg.char_valid;
    assign tok_out.char_out    = slot0_reg.char_out;
    assign tok_out.token_start = slot0_reg.token_start;
    assign tok_out.token_end   = slot0_reg.token_end;
    assign tok_out.line_number = slot0_reg.line_number;
    assign tok_out.error_code  = slot0_reg.error_code;
    assign tok_out.last_result = slot0_reg.last_result;

endmodule

`default_nettype wire

### hw/rtl/ctt_checker.sv
// Port-level checks of the tokeniser, bound to its top level.
`default_nettype none

module ctt_checker (
    input wire        clk,
    input wire        rst_n,
    input wire        out_valid,
    input wire        out_ready,
    input wire [4:0]  token_kind,
    input wire        char_valid,
    input wire [7:0]  char_out,
    input wire [15:0] line_number,
    input wire [1:0]  error_code,
    input wire        last_result
);

    // A stalled result item keeps its payload.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(token_kind) && $stable(char_out)
            && $stable(last_result) && $stable(error_code))
    else $error("stalled result item changed");

    // Only content items carry a character.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !char_valid |-> char_out == 8'h00)
    else $error("character shown without char_valid");

    // Errors appear only on error items or on the end item of an open string.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && error_code != ctt_pkg::ERR_NONE |->
            token_kind == ctt_pkg::KIND_NONE
            || (token_kind == ctt_pkg::KIND_END && error_code == ctt_pkg::ERR_UNTERM))
    else $error("error code on an ordinary token");

    // The line count starts at one and never wraps to zero.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> line_number != 16'd0)
    else $error("line number zero");

endmodule

bind config_text_tokenizer ctt_checker u_ctt_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .out_valid   (tok_out.valid),
    .out_ready   (tok_out.ready),
    .token_kind  (tok_out.token_kind),
    .char_valid  (tok_out.char_valid),
    .char_out    (tok_out.char_out),
    .line_number (tok_out.line_number),
    .error_code  (tok_out.error_code),
    .last_result (tok_out.last_result)
);

`default_nettype wire

### verif/tb_top.sv
// Self-checking testbench for the configuration text tokeniser.
`timescale 1ns / 100ps

module tb_top;

    // The line counter is made narrower than the line field of the results.
    localparam int LINE_BITS = 8;
    localparam int STALL_LIMIT = 2000;

    // How a stimulus row is checked.
    localparam logic [1:0] CHECK_PREDICTED = 2'd0;
    localparam logic [1:0] CHECK_SILENT    = 2'd1;
    localparam logic [1:0] CHECK_TYPED     = 2'd2;

    localparam ctt_pkg::result_t NO_RES = '0;

    localparam logic [7:0] PUNCT [0:22] = '{
        ".", ",", ":", ";", "@", "#", "$", "%", "^", "&", "*", "+",
        "-", "/", "\\", "(", ")", "[", "]", "{", "}", "<", ">"
    };

    typedef struct packed {
        logic [7:0]       ch;
        logic             eoi;
        logic [1:0]       check;
        ctt_pkg::result_t res;
    } stim_row_t;

    localparam int DIRECTED_ROWS = 24;
    localparam int UNKNOWN_TAIL  = 24;
    localparam int UNTERM_TAIL   = 28;
    localparam int TABLE_ROWS    = 33;

    // Rows before DIRECTED_ROWS open the run; one of the two error tails closes it.
    localparam stim_row_t STIM [0:TABLE_ROWS-1] = '{
        '{ctt_pkg::CH_NEWLINE, 1'b0, CHECK_TYPED,
          '{ctt_pkg::KIND_NEWLINE, 1'b0, 8'h00, 1'b1, 1'b1, 16'd1, ctt_pkg::ERR_NONE, 1'b1}},
        '{" ", 1'b0, CHECK_SILENT, NO_RES},
        '{8'h09, 1'b0, CHECK_SILENT, NO_RES},
        '{8'h0D, 1'b0, CHECK_SILENT, NO_RES},
        '{"t", 1'b0, CHECK_PREDICTED, NO_RES},
        '{"r", 1'b0, CHECK_PREDICTED, NO_RES},
        '{"u", 1'b0, CHECK_PREDICTED, NO_RES},
        '{"e", 1'b0, CHECK_PREDICTED, NO_RES},
        '{";", 1'b0, CHECK_PREDICTED, NO_RES},
        '{"f", 1'b0, CHECK_PREDICTED, NO_RES},
        '{"a", 1'b0, CHECK_PREDICTED, NO_RES},
        '{"l", 1'b0, CHECK_PREDICTED, NO_RES},
        '{"s", 1'b0, CHECK_PREDICTED, NO_RES},
        '{"e", 1'b0, CHECK_PREDICTED, NO_RES},
        '{8'hFF, 1'b1, CHECK_PREDICTED, NO_RES},
        '{ctt_pkg::CH_UNDERSCORE, 1'b0, CHECK_TYPED,
          '{ctt_pkg::KIND_IDENT, 1'b1, ctt_pkg::CH_UNDERSCORE, 1'b1, 1'b0, 16'd1,
            ctt_pkg::ERR_NONE, 1'b1}},
        '{"9", 1'b0, CHECK_PREDICTED, NO_RES},
        '{" ", 1'b0, CHECK_PREDICTED, NO_RES},
        '{"0", 1'b0, CHECK_TYPED,
          '{ctt_pkg::KIND_NUMBER, 1'b1, "0", 1'b1, 1'b0, 16'd1, ctt_pkg::ERR_NONE, 1'b1}},
        '{ctt_pkg::CH_PERIOD, 1'b0, CHECK_PREDICTED, NO_RES},
        '{ctt_pkg::CH_PERIOD, 1'b0, CHECK_PREDICTED, NO_RES},
        '{ctt_pkg::CH_QUOTE, 1'b0, CHECK_PREDICTED, NO_RES},
        '{ctt_pkg::CH_NEWLINE, 1'b0, CHECK_PREDICTED, NO_RES},
        '{ctt_pkg::CH_QUOTE, 1'b0, CHECK_PREDICTED, NO_RES},
        // End mark, then an unknown byte and the sticky error.
        '{8'h00, 1'b1, CHECK_PREDICTED, NO_RES},
        '{8'h80, 1'b0, CHECK_TYPED,
          '{ctt_pkg::KIND_NONE, 1'b0, 8'h00, 1'b0, 1'b0, 16'd1, ctt_pkg::ERR_CHAR, 1'b1}},
        '{"a", 1'b0, CHECK_TYPED,
          '{ctt_pkg::KIND_NONE, 1'b0, 8'h00, 1'b0, 1'b0, 16'd1, ctt_pkg::ERR_CHAR, 1'b1}},
        '{8'h7F, 1'b1, CHECK_TYPED,
          '{ctt_pkg::KIND_NONE, 1'b0, 8'h00, 1'b0, 1'b0, 16'd1, ctt_pkg::ERR_CHAR, 1'b1}},
        // String left open at the end of the text, then the sticky error.
        '{8'h00, 1'b1, CHECK_PREDICTED, NO_RES},
        '{ctt_pkg::CH_QUOTE, 1'b0, CHECK_TYPED,
          '{ctt_pkg::KIND_STRING, 1'b0, 8'h00, 1'b1, 1'b0, 16'd1, ctt_pkg::ERR_NONE, 1'b1}},
        '{8'hC3, 1'b0, CHECK_TYPED,
          '{ctt_pkg::KIND_STRING, 1'b1, 8'hC3, 1'b0, 1'b0, 16'd1, ctt_pkg::ERR_NONE, 1'b1}},
        '{8'h5A, 1'b1, CHECK_TYPED,
          '{ctt_pkg::KIND_END, 1'b0, 8'h00, 1'b1, 1'b1, 16'd1, ctt_pkg::ERR_UNTERM, 1'b1}},
        '{"x", 1'b0, CHECK_TYPED,
          '{ctt_pkg::KIND_NONE, 1'b0, 8'h00, 1'b0, 1'b0, 16'd1, ctt_pkg::ERR_UNTERM, 1'b1}}
    };

    logic clk = 1'b0;
    logic rst_n;

    ctt_in_if  tok_in();
    ctt_out_if tok_out();

    config_text_tokenizer #(.LINE_BITS(LINE_BITS)) dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .tok_in  (tok_in),
        .tok_out (tok_out)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // Tokeniser state as the testbench tracks it.
    ctt_pkg::mode_t       lex_state;
    logic                 seen_period;
    logic [39:0]          word_bits;
    int                   word_len;
    logic [LINE_BITS-1:0] line_cnt;

    ctt_pkg::result_t byte_tokens[$];
    ctt_pkg::result_t pending_tokens[$];

    int mismatches = 0;
    int idle_cycles = 0;
    int items_sent = 0;
    bit calm_tail = 1'b0;
    bit gaps_on = 1'b1;

    function automatic logic letter_byte(input logic [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
    endfunction

    function automatic logic digit_byte(input logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic logic blank_byte(input logic [7:0] c);
        return c == " " || (c >= 8'h09 && c <= 8'h0D);
    endfunction

    function automatic logic [4:0] punct_kind(input logic [7:0] c);
        for (int i = 0; i < 23; i++)
        begin
            if (PUNCT[i] == c)
                return ctt_pkg::KIND_SYM0 + 5'(i);
        end
        return ctt_pkg::KIND_NONE;
    endfunction

    function automatic logic known_byte(input logic [7:0] c);
        return letter_byte(c) || digit_byte(c) || c == ctt_pkg::CH_UNDERSCORE
            || c == ctt_pkg::CH_QUOTE || blank_byte(c) || punct_kind(c) != ctt_pkg::KIND_NONE;
    endfunction

    function automatic void add_token(input logic [4:0] kind, input logic cv,
                                      input logic [7:0] ch, input logic st,
                                      input logic en, input logic [1:0] err);
        ctt_pkg::result_t r;
        r.token_kind  = kind;
        r.char_valid  = cv;
        r.char_out    = cv ? ch : 8'h00;
        r.token_start = st;
        r.token_end   = en;
        r.line_number = 16'(line_cnt);
        r.error_code  = err;
        r.last_result = 1'b0;
        byte_tokens = {byte_tokens, r};
    endfunction

    // Works out the results of one item and advances the tracked state.
    function automatic void tokenize_byte(input logic [7:0] b, input logic eoi);
        logic fresh;
        logic is_bool;
        byte_tokens.delete();
        fresh = 1'b0;
        case (lex_state)
            ctt_pkg::MODE_ERR_CHAR:
                add_token(ctt_pkg::KIND_NONE, 1'b0, 8'h00, 1'b0, 1'b0, ctt_pkg::ERR_CHAR);
            ctt_pkg::MODE_ERR_STR:
                add_token(ctt_pkg::KIND_NONE, 1'b0, 8'h00, 1'b0, 1'b0, ctt_pkg::ERR_UNTERM);
            ctt_pkg::MODE_STR:
            begin
                if (eoi)
                begin
                    add_token(ctt_pkg::KIND_END, 1'b0, 8'h00, 1'b1, 1'b1, ctt_pkg::ERR_UNTERM);
                    lex_state = ctt_pkg::MODE_ERR_STR;
                end
                else if (b == ctt_pkg::CH_QUOTE)
                begin
                    add_token(ctt_pkg::KIND_STRING, 1'b0, 8'h00, 1'b0, 1'b1, ctt_pkg::ERR_NONE);
                    lex_state = ctt_pkg::MODE_IDLE;
                end
                else
                    add_token(ctt_pkg::KIND_STRING, 1'b1, b, 1'b0, 1'b0, ctt_pkg::ERR_NONE);
            end
            ctt_pkg::MODE_IDENT:
            begin
                if (!eoi && (letter_byte(b) || digit_byte(b) || b == ctt_pkg::CH_UNDERSCORE))
                begin
                    word_bits = {word_bits[31:0], b};
                    if (word_len < 6)
                        word_len++;
                    add_token(ctt_pkg::KIND_IDENT, 1'b1, b, 1'b0, 1'b0, ctt_pkg::ERR_NONE);
                end
                else
                begin
                    is_bool = (word_len == 4 && word_bits[31:0] == "true")
                        || (word_len == 5 && word_bits == "false");
                    add_token(is_bool ? ctt_pkg::KIND_BOOL : ctt_pkg::KIND_IDENT, 1'b0, 8'h00,
                              1'b0, 1'b1, ctt_pkg::ERR_NONE);
                    lex_state = ctt_pkg::MODE_IDLE;
                    fresh = 1'b1;
                end
            end
            ctt_pkg::MODE_NUM:
            begin
                if (!eoi && (digit_byte(b) || (b == ctt_pkg::CH_PERIOD && !seen_period)))
                begin
                    if (b == ctt_pkg::CH_PERIOD)
                        seen_period = 1'b1;
                    add_token(ctt_pkg::KIND_NUMBER, 1'b1, b, 1'b0, 1'b0, ctt_pkg::ERR_NONE);
                end
                else
                begin
                    add_token(ctt_pkg::KIND_NUMBER, 1'b0, 8'h00, 1'b0, 1'b1, ctt_pkg::ERR_NONE);
                    lex_state = ctt_pkg::MODE_IDLE;
                    fresh = 1'b1;
                end
            end
            default:
                fresh = 1'b1;
        endcase

        // A byte in the idle mode, or one that closed a token, is taken as the start of the next.
        if (fresh)
        begin
            if (eoi)
            begin
                add_token(ctt_pkg::KIND_END, 1'b0, 8'h00, 1'b1, 1'b1, ctt_pkg::ERR_NONE);
                line_cnt = LINE_BITS'(1);
            end
            else if (b == ctt_pkg::CH_NEWLINE)
            begin
                add_token(ctt_pkg::KIND_NEWLINE, 1'b0, 8'h00, 1'b1, 1'b1, ctt_pkg::ERR_NONE);
                if (line_cnt != '1)
                    line_cnt++;
            end
            else if (blank_byte(b))
            begin
            end
            else if (letter_byte(b) || b == ctt_pkg::CH_UNDERSCORE)
            begin
                lex_state = ctt_pkg::MODE_IDENT;
                word_bits = {32'h0, b};
                word_len = 1;
                add_token(ctt_pkg::KIND_IDENT, 1'b1, b, 1'b1, 1'b0, ctt_pkg::ERR_NONE);
            end
            else if (b == ctt_pkg::CH_QUOTE)
            begin
                lex_state = ctt_pkg::MODE_STR;
                add_token(ctt_pkg::KIND_STRING, 1'b0, 8'h00, 1'b1, 1'b0, ctt_pkg::ERR_NONE);
            end
            else if (digit_byte(b))
            begin
                lex_state = ctt_pkg::MODE_NUM;
                seen_period = 1'b0;
                add_token(ctt_pkg::KIND_NUMBER, 1'b1, b, 1'b1, 1'b0, ctt_pkg::ERR_NONE);
            end
            else if (punct_kind(b) != ctt_pkg::KIND_NONE)
                add_token(punct_kind(b), 1'b0, 8'h00, 1'b1, 1'b1, ctt_pkg::ERR_NONE);
            else
            begin
                lex_state = ctt_pkg::MODE_ERR_CHAR;
                add_token(ctt_pkg::KIND_NONE, 1'b0, 8'h00, 1'b0, 1'b0, ctt_pkg::ERR_CHAR);
            end
        end

        if (byte_tokens.size() > 0)
            byte_tokens[byte_tokens.size() - 1].last_result = 1'b1;
    endfunction

    task automatic push_item(input logic [7:0] b, input logic eoi, input logic [1:0] check,
                             input ctt_pkg::result_t typed);
        if (!calm_tail && gaps_on && $urandom_range(0, 3) == 0)
        begin
            @(negedge clk);
            tok_in.valid <= 1'b0;
            repeat ($urandom_range(0, 13)) @(negedge clk);
        end
        @(negedge clk);
        tok_in.valid        <= 1'b1;
        tok_in.byte_in      <= b;
        tok_in.end_of_input <= eoi;
        @(posedge clk);
        while (!tok_in.ready)
            @(posedge clk);
        items_sent++;
        tokenize_byte(b, eoi);
        if (check == CHECK_PREDICTED)
        begin
            foreach (byte_tokens[i])
                pending_tokens = {pending_tokens, byte_tokens[i]};
        end
        else if (check == CHECK_TYPED)
            pending_tokens = {pending_tokens, typed};
    endtask

    task automatic send_byte(input logic [7:0] b);
        push_item(b, 1'b0, CHECK_PREDICTED, NO_RES);
    endtask

    function automatic logic [7:0] word_char();
        case ($urandom_range(0, 3))
            0:       return 8'("a" + $urandom_range(0, 25));
            1:       return 8'("A" + $urandom_range(0, 25));
            2:       return 8'("0" + $urandom_range(0, 9));
            default: return ctt_pkg::CH_UNDERSCORE;
        endcase
    endfunction

    // One random run of bytes: mostly well-formed tokens, some noise.
    task automatic gen_sequence();
        logic [39:0] word;
        logic [7:0]  c;
        int          wlen;
        int          keep;
        int          pick;
        gaps_on = ($urandom_range(0, 2) != 0);
        pick = $urandom_range(0, 19);
        if (pick < 3)
        begin
            // Keyword, sometimes cut short or run on into a longer word.
            if ($urandom_range(0, 1))
            begin
                word = "false";
                wlen = 5;
            end
            else
            begin
                word = {8'h00, "true"};
                wlen = 4;
            end
            keep = ($urandom_range(0, 2) != 0) ? wlen : $urandom_range(1, wlen - 1);
            for (int k = 0; k < keep; k++)
                send_byte(word[8 * (wlen - 1 - k) +: 8]);
            if ($urandom_range(0, 3) == 0)
                send_byte(word_char());
        end
        else if (pick < 6)
        begin
            do
                c = word_char();
            while (digit_byte(c));
            send_byte(c);
            repeat ($urandom_range(0, 7)) send_byte(word_char());
        end
        else if (pick < 9)
        begin
            send_byte(8'("0" + $urandom_range(0, 9)));
            repeat ($urandom_range(0, 5))
            begin
                if ($urandom_range(0, 4) == 0)
                    send_byte(ctt_pkg::CH_PERIOD);
                else
                    send_byte(8'("0" + $urandom_range(0, 9)));
            end
        end
        else if (pick < 12)
        begin
            send_byte(ctt_pkg::CH_QUOTE);
            repeat ($urandom_range(0, 8))
            begin
                do
                    c = 8'($urandom_range(0, 255));
                while (c == ctt_pkg::CH_QUOTE);
                send_byte(c);
            end
            send_byte(ctt_pkg::CH_QUOTE);
        end
        else if (pick < 14)
            send_byte(PUNCT[$urandom_range(0, 22)]);
        else if (pick < 16)
        begin
            repeat ($urandom_range(1, 3))
                send_byte($urandom_range(0, 1) ? " " : 8'($urandom_range(9, 13)));
        end
        else if (pick < 17)
        begin
            // An open string must be closed first, or the error would stick.
            if (lex_state == ctt_pkg::MODE_STR)
                send_byte(ctt_pkg::CH_QUOTE);
            push_item(8'($urandom_range(0, 255)), 1'b1, CHECK_PREDICTED, NO_RES);
        end
        else
        begin
            // A lone quote here would leave a string open for the next run.
            repeat ($urandom_range(1, 4))
            begin
                do
                    c = 8'($urandom_range(0, 127));
                while (!known_byte(c) || c == ctt_pkg::CH_QUOTE);
                send_byte(c);
            end
        end
    endtask

    task automatic report_mismatch(input string what, input ctt_pkg::result_t want,
                                   input ctt_pkg::result_t got);
        mismatches++;
        if (mismatches <= 10)
            $display("%s: expected kind %0d cv %0b ch %02h st %0b en %0b line %0d err %0d %s",
                     what, want.token_kind, want.char_valid, want.char_out, want.token_start,
                     want.token_end, want.line_number, want.error_code,
                     $sformatf("last %0b,", want.last_result),
                     "\n    got kind %0d cv %0b ch %02h st %0b en %0b line %0d err %0d last %0b",
                     got.token_kind, got.char_valid, got.char_out, got.token_start,
                     got.token_end, got.line_number, got.error_code, got.last_result);
    endtask

    // Result checker and watchdog.
    always @(posedge clk)
    begin
        ctt_pkg::result_t got;
        ctt_pkg::result_t want;
        if (rst_n)
        begin
            if (tok_out.valid && tok_out.ready)
            begin
                got = {tok_out.token_kind, tok_out.char_valid, tok_out.char_out,
                       tok_out.token_start, tok_out.token_end, tok_out.line_number,
                       tok_out.error_code, tok_out.last_result};
                if (pending_tokens.size() == 0)
                    report_mismatch("unexpected result", NO_RES, got);
                else
                begin
                    want = pending_tokens.pop_front();
                    if (got !== want)
                        report_mismatch("wrong result", want, got);
                end
            end
            if ((tok_out.valid && tok_out.ready) || (tok_in.valid && tok_in.ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= STALL_LIMIT)
            begin
                $display("config_text_tokenizer test failed");
                $finish;
            end
        end
    end

    // Receiver back-pressure in bursts, with calm stretches in between.
    initial
    begin
        int  stall_left;
        bit  calm;
        stall_left = 0;
        calm = 1'b0;
        tok_out.ready = 1'b1;
        forever
        begin
            @(negedge clk);
            if ($urandom_range(0, 149) == 0)
                calm = !calm;
            if (stall_left == 0 && !calm && !calm_tail && $urandom_range(0, 5) == 0)
                stall_left = $urandom_range(1, 14);
            if (stall_left > 0)
            begin
                tok_out.ready <= 1'b0;
                stall_left--;
            end
            else
                tok_out.ready <= 1'b1;
        end
    end

    initial
    begin
        int first_row;
        int end_row;
        int stop_at;
        tok_in.valid = 1'b0;
        tok_in.byte_in = 8'h00;
        tok_in.end_of_input = 1'b0;
        rst_n = 1'b0;
        lex_state = ctt_pkg::MODE_IDLE;
        seen_period = 1'b0;
        word_bits = '0;
        word_len = 0;
        line_cnt = LINE_BITS'(1);
        repeat (10) @(negedge clk);
        rst_n = 1'b1;

        for (int i = 0; i < DIRECTED_ROWS; i++)
            push_item(STIM[i].ch, STIM[i].eoi, STIM[i].check, STIM[i].res);

        while (items_sent < 190)
            gen_sequence();

        calm_tail = 1'b1;
        stop_at = items_sent + 50;
        while (items_sent < stop_at)
            gen_sequence();
        if (lex_state == ctt_pkg::MODE_STR)
            send_byte(ctt_pkg::CH_QUOTE);

        // Only one sticky error can be seen per run, as reset is not repeated.
        if ($urandom_range(0, 1))
        begin
            first_row = UNKNOWN_TAIL;
            end_row = UNTERM_TAIL;
        end
        else
        begin
            first_row = UNTERM_TAIL;
            end_row = TABLE_ROWS;
        end
        for (int i = first_row; i < end_row; i++)
            push_item(STIM[i].ch, STIM[i].eoi, STIM[i].check, STIM[i].res);

        @(negedge clk);
        tok_in.valid <= 1'b0;
        while (pending_tokens.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);

        if (mismatches == 0 && pending_tokens.size() == 0)
            $display("config_text_tokenizer test passed");
        else
            $display("config_text_tokenizer test failed");
        $finish;
    end

endmodule

### config_text_tokenizer.f
hw/rtl/ctt_pkg.sv
hw/rtl/ctt_in_if.sv
hw/rtl/ctt_out_if.sv
hw/rtl/config_text_tokenizer.sv
hw/rtl/ctt_checker.sv
verif/tb_top.sv
